// ----- src/swa_pkg.sv -----
// Shared types and constants of the sliding window average block.
package swa_pkg;

	localparam int WS_W   = 9;
	localparam int AVG_W  = 24;
	localparam int REP_W  = 8;
	localparam int FRAC_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_stall;
		logic upd;
		logic ram_we;
		logic div_step;
		logic out_load;
	} ctl_t;

endpackage

// ----- src/swa_ram.sv -----
// Generic single write port RAM with registered read.
module swa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sliding_window_average.sv -----
// Top level of the sliding window average: delay line, running sum, bit-serial divider.
// A request passes through ST_READ, which updates the sum and delay line; if it yields a result,
// the bit-serial divider in ST_DIV retires one quotient bit a cycle and ST_DONE loads the output.
// A request that yields no result returns from ST_READ to ST_IDLE. No new request is taken
// before the last is through. The next request is taken while a result waits on a stalled output.
// Reset clears the running sum, counts, pointer and window size (to 1), not the delay line.
module sliding_window_average #(
	parameter int MAX_WINDOW  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [swa_pkg::WS_W-1:0]         cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [swa_pkg::AVG_W-1:0] average,
	output logic [swa_pkg::REP_W-1:0]        repeat_res,
	output logic                             final_res
);

	import swa_pkg::*;

	localparam int CW    = $clog2(MAX_WINDOW + 1);
	localparam int PW    = $clog2(MAX_WINDOW);
	localparam int XW    = (CW > WS_W) ? CW : WS_W;
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int QW    = SUM_W + FRAC_W;
	localparam int CNT_W = $clog2(QW + 1);

	state_t state_q, state_d;
	ctl_t   ctl;

	logic [WS_W-1:0]              window_size_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [CW-1:0]                seen_q;
	logic [PW-1:0]                ptr_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                         last_q;
	logic [CW-1:0]                rem_q;
	logic [QW-1:0]                quo_q;
	logic [CW-1:0]                n_q;
	logic                         neg_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [REP_W-1:0]             rep_q;
	logic                         fin_q;
	logic                         out_valid_q;
	logic signed [AVG_W-1:0]      average_q;
	logic [REP_W-1:0]             repeat_q;
	logic                         final_q;

	logic [XW-1:0]                ws_x;
	logic [CW-1:0]                w_eff;
	logic [SAMPLE_BITS-1:0]       old_sample;
	logic                         full_old;
	logic signed [SUM_W-1:0]      sum_new;
	logic [CW-1:0]                seen_new;
	logic                         has_full;
	logic                         has_res;
	logic [CW-1:0]                ptr_inc;
	logic [PW-1:0]                ptr_next;
	logic [SUM_W-1:0]             mag;
	logic [CW:0]                  trial;
	logic                         ge;
	logic [QW-1:0]                quo_signed;
	logic                         out_free;

	swa_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (ctl.ram_we),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (ptr_q),
		.rdata (old_sample)
	);

	always_comb begin
		ws_x = XW'(window_size_q);
		if (ws_x == '0) begin
			w_eff = CW'(1);
		end else if (ws_x > XW'(MAX_WINDOW)) begin
			w_eff = CW'(MAX_WINDOW);
		end else begin
			w_eff = CW'(ws_x);
		end
	end

	always_comb begin
		full_old = (seen_q >= w_eff);
		sum_new  = sum_q + SUM_W'(sample_q)
			- (full_old ? SUM_W'($signed(old_sample)) : SUM_W'(0));
		seen_new = full_old ? seen_q : seen_q + CW'(1);
		has_full = (seen_new >= w_eff);
		has_res  = has_full || last_q;
		ptr_inc  = CW'(ptr_q) + CW'(1);
		ptr_next = (ptr_inc == w_eff) ? '0 : PW'(ptr_inc);
		mag      = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
		trial    = {rem_q, quo_q[QW-1]};
		ge       = (trial >= {1'b0, n_q});
		quo_signed = neg_q ? QW'(-quo_q) : quo_q;
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = has_res ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.in_stall = 1'b0;
			ST_READ: begin
				ctl.in_stall = 1'b1;
				ctl.upd      = 1'b1;
				ctl.ram_we   = 1'b1;
			end
			ST_DIV: begin
				ctl.in_stall = 1'b1;
				ctl.div_step = 1'b1;
			end
			ST_DONE: begin
				ctl.in_stall = 1'b1;
				ctl.out_load = out_free;
			end
			default: ctl.in_stall = 1'b1;
		endcase
	end

	assign in_stall = ctl.in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WS_W'(1);
			sum_q         <= '0;
			seen_q        <= '0;
			ptr_q         <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				window_size_q <= cfg_wr_data;
				sum_q         <= '0;
				seen_q        <= '0;
				ptr_q         <= '0;
			end else if (ctl.upd) begin
				if (last_q) begin
					sum_q  <= '0;
					seen_q <= '0;
					ptr_q  <= '0;
				end else begin
					sum_q  <= sum_new;
					seen_q <= seen_new;
					ptr_q  <= ptr_next;
				end
			end
			if (ctl.upd) begin
				cnt_q <= CNT_W'(QW);
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !ctl.in_stall) begin
			sample_q <= sample;
			last_q   <= last;
		end
		if (ctl.upd) begin
			quo_q <= {mag, FRAC_W'(0)};
			rem_q <= '0;
			n_q   <= seen_new;
			neg_q <= sum_new[SUM_W-1];
			rep_q <= has_full ? REP_W'(1) : REP_W'(seen_new);
			fin_q <= last_q;
		end else if (ctl.div_step) begin
			quo_q <= {quo_q[QW-2:0], ge};
			rem_q <= ge ? CW'(trial - {1'b0, n_q}) : CW'(trial);
		end
		if (ctl.out_load) begin
			average_q <= AVG_W'($signed(quo_signed));
			repeat_q  <= rep_q;
			final_q   <= fin_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign average    = average_q;
	assign repeat_res = repeat_q;
	assign final_res  = final_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= w_eff)
		else $error("sample count exceeds window");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(ptr_q) < w_eff)
		else $error("write pointer outside window");

	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < w_eff |-> CW'(ptr_q) == seen_q)
		else $error("pointer and count disagree while filling");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divider running with no steps left");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && state_d == ST_IDLE |=> out_valid_q)
		else $error("result lost on leaving done state");

endmodule

// ----- tb/sv/sliding_window_average_tb.sv -----
// Self-checking testbench for the sliding window average: random streams, window settings, stalls.
module sliding_window_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swa_pkg::*;

	localparam int SAMPLE_W      = 16;
	localparam int MAX_WIN       = 256;
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_HOLD     = 600;
	localparam int DRAIN_CAP     = 20000;

	typedef enum int {
		MODE_RANDOM,
		MODE_EXTREME,
		MODE_SMALL
	} fill_mode_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       closes;
	} sample_req_t;

	typedef struct packed {
		logic signed [AVG_W-1:0] mean;
		logic [REP_W-1:0]        copies;
		logic                    closing;
	} mean_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [WS_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [AVG_W-1:0] average;
	logic [REP_W-1:0] repeat_res;
	logic final_res;

	sample_req_t  pending_samples[$];
	mean_result_t expected_means[$];

	logic signed [SAMPLE_W-1:0] delay_line [0:MAX_WIN-1];
	longint      window_sum;
	int unsigned fill_count;
	int unsigned slot_ptr;
	logic [WS_W-1:0] win_reg;

	int  errors = 0;
	bit  idling_on = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_requests = 0;
	int  holds_served = 0;
	logic stall_next;
	sample_req_t next_req;
	mean_result_t want;

	sliding_window_average #(
		.MAX_WINDOW (MAX_WIN),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.average    (average),
		.repeat_res (repeat_res),
		.final_res  (final_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned active_window();
		if (win_reg == 0)
			return 1;
		if (win_reg > MAX_WIN)
			return MAX_WIN;
		return 32'(win_reg);
	endfunction

	function automatic logic [AVG_W-1:0] q_mean(longint total, int unsigned n);
		longint q;
		q = (total * 256) / longint'(n);
		return q[AVG_W-1:0];
	endfunction

	function automatic void clear_stream();
		window_sum = 0;
		fill_count = 0;
		slot_ptr = 0;
	endfunction

	function automatic void predict_average(logic signed [SAMPLE_W-1:0] s, logic closes);
		int unsigned w;
		int unsigned slot;
		mean_result_t r;
		w = active_window();
		slot = slot_ptr % w;
		if (fill_count >= w)
			window_sum -= delay_line[slot];
		window_sum += s;
		delay_line[slot] = s;
		slot_ptr = (slot + 1 == w) ? 0 : slot + 1;
		if (fill_count < w)
			fill_count++;
		if (fill_count >= w) begin
			r.mean = q_mean(window_sum, w);
			r.copies = REP_W'(1);
			r.closing = closes;
			expected_means.push_back(r);
		end else if (closes) begin
			r.mean = q_mean(window_sum, fill_count);
			r.copies = fill_count[REP_W-1:0];
			r.closing = 1'b1;
			expected_means.push_back(r);
		end
		if (closes)
			clear_stream();
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 80) : $urandom_range(1, 3);
	endfunction

	function automatic int pick_length(int unsigned w);
		case ($urandom_range(0, 9))
			0, 1, 2: return (w > 1) ? $urandom_range(1, w - 1) : 1;
			3:       return w;
			default: return w + $urandom_range(1, 24);
		endcase
	endfunction

	// driver: offer queued requests, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_average(sample, last);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					next_req = pending_samples.pop_front();
					in_valid <= 1'b1;
					sample <= next_req.value;
					last <= next_req.closes;
					if (idling_on && $urandom_range(0, 2) == 0)
						gap_left = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, drive receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_means.size() == 0) begin
					$error("unexpected result: average %0d, repeat_res %0d, final_res %0d",
						average, repeat_res, final_res);
					errors++;
				end else begin
					want = expected_means.pop_front();
					if (average !== want.mean) begin
						$error("average: expected %0d, got %0d", want.mean, average);
						errors++;
					end
					if (repeat_res !== want.copies) begin
						$error("repeat_res: expected %0d, got %0d", want.copies, repeat_res);
						errors++;
					end
					if (final_res !== want.closing) begin
						$error("final_res: expected %0d, got %0d", want.closing, final_res);
						errors++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	task automatic write_window(logic [WS_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_reg = v;
		clear_stream();
	endtask

	task automatic queue_one(logic signed [SAMPLE_W-1:0] v, logic closes);
		sample_req_t req;
		req.value = v;
		req.closes = closes;
		pending_samples.push_back(req);
	endtask

	task automatic queue_stream(int len, bit closed, fill_mode_t mode);
		logic signed [SAMPLE_W-1:0] extreme;
		logic signed [SAMPLE_W-1:0] v;
		extreme = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		for (int i = 0; i < len; i++) begin
			case (mode)
				MODE_EXTREME: v = extreme;
				MODE_SMALL:   v = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
				default:      v = SAMPLE_W'($urandom());
			endcase
			queue_one(v, closed && (i == len - 1));
		end
	endtask

	task automatic drain_block();
		int waited = 0;
		do @(negedge clk); while (pending_samples.size() != 0 || in_valid);
		while (expected_means.size() != 0 && waited < DRAIN_CAP) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(logic [WS_W-1:0] win_value, int budget, bit with_idling,
			bit with_hold, bit leave_open);
		int unsigned w;
		int len;
		int queued = 0;
		fill_mode_t mode;
		write_window(win_value);
		w = active_window();
		@(negedge clk);
		idling_on = with_idling;
		if (with_hold)
			hold_requests++;
		while (queued < budget) begin
			case ($urandom_range(0, 7))
				0:       mode = MODE_EXTREME;
				1:       mode = MODE_SMALL;
				default: mode = MODE_RANDOM;
			endcase
			len = pick_length(w);
			queue_stream(len, 1'b1, mode);
			queued += len;
		end
		// leave a stream open so the next write lands mid-stream
		if (leave_open)
			queue_stream($urandom_range(1, w + 3), 1'b0, MODE_RANDOM);
		drain_block();
	endtask

	initial begin
		for (int i = 0; i < MAX_WIN; i++)
			delay_line[i] = '0;
		win_reg = 1;
		clear_stream();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_one(16'sh7FFF, 1'b0);
		queue_one(16'sh8000, 1'b0);
		queue_one(16'sd0, 1'b0);
		queue_one(-16'sd1, 1'b1);
		queue_one(16'sd1, 1'b1);
		drain_block();

		write_window(9'd0);
		@(negedge clk);
		queue_one(16'sd12345, 1'b1);
		queue_one(-16'sd7, 1'b0);
		drain_block();

		write_window(9'd4);
		@(negedge clk);
		queue_one(16'sd100, 1'b0);
		queue_one(-16'sd3, 1'b1);
		repeat (3) queue_one(16'sh7FFF, 1'b0);
		queue_one(16'sh7FFF, 1'b1);
		repeat (4) queue_one(16'sh8000, 1'b0);
		queue_one(16'sd5, 1'b0);
		queue_one(16'sd6, 1'b0);
		drain_block();

		write_window(9'd3);
		@(negedge clk);
		queue_one(16'sd1, 1'b0);
		queue_one(16'sd2, 1'b0);
		queue_one(16'sd3, 1'b1);
		drain_block();

		run_phase(9'd2, 120, 1'b1, 1'b1, 1'b1);
		run_phase(9'd1, 80, 1'b0, 1'b0, 1'b0);
		run_phase(9'd13, 120, 1'b1, 1'b0, 1'b1);
		run_phase(9'd0, 60, 1'b1, 1'b0, 1'b0);
		run_phase(WS_W'($urandom_range(3, 40)), 120, 1'b1, 1'b1, 1'b1);
		run_phase(WS_W'($urandom_range(5, 64)), 100, 1'b1, 1'b0, 1'b0);

		write_window(9'd256);
		@(negedge clk);
		idling_on = 1'b1;
		queue_stream(MAX_WIN - 1, 1'b1, MODE_RANDOM);
		drain_block();

		write_window(9'd511);
		@(negedge clk);
		queue_stream(MAX_WIN + 12, 1'b1, MODE_EXTREME);
		queue_stream(20, 1'b0, MODE_RANDOM);
		drain_block();

		write_window(9'd300);
		@(negedge clk);
		queue_stream(20, 1'b1, MODE_RANDOM);
		drain_block();

		run_phase(9'd6, 100, 1'b1, 1'b0, 1'b0);

		if (expected_means.size() != 0) begin
			$error("%0d expected results never arrived", expected_means.size());
			errors++;
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sliding_window_average.f -----
src/swa_pkg.sv
src/swa_ram.sv
src/sliding_window_average.sv
tb/sv/sliding_window_average_tb.sv
